FILE: hw/rtl/mde_pkg.sv
// Shared types, constants and helper functions of the multicast destination expander.
`default_nettype none

package mde_pkg;

    localparam int MAX_RANK   = 4;
    localparam int MAX_NODES  = 64;
    localparam int DEST_W     = 10;
    localparam int NODE_W     = 6;
    localparam int EXT_W      = 7;
    localparam int RANK_W     = 3;
    localparam int DIM_IDX_W  = 2;
    localparam int CNT_W      = 7;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_RANK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_CODE,
        S_CLASSIFY,
        S_START_DIGIT,
        S_DIGIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [RANK_W-1:0]               array_rank;
        logic [MAX_RANK-1:0][EXT_W-1:0]  dim_size;
        logic [EXT_W-1:0]                processor_count;
    } t_cfg;

    typedef struct packed {
        logic cap_in;
        logic cap_code;
        logic start_digit;
        logic cap_digit;
        logic emit_single;
        logic emit_sweep;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic is_full;
        logic is_zero;
        logic digit_last;
        logic emit_last;
        logic out_free;
    } t_sts;

    // A zero extent or node count behaves as one.
    function automatic logic [EXT_W-1:0] extent_eff(input logic [EXT_W-1:0] v);
        extent_eff = (v == '0) ? EXT_W'(1) : v;
    endfunction

    // Rank zero behaves as one; ranks above the maximum are clamped.
    function automatic logic [RANK_W-1:0] rank_eff(input logic [RANK_W-1:0] r);
        if (r == '0) begin
            rank_eff = RANK_W'(1);
        end else if (r > RANK_W'(MAX_RANK)) begin
            rank_eff = RANK_W'(MAX_RANK);
        end else begin
            rank_eff = r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mde_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none

module mde_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mde_pkg::DEST_W-1:0]  i_dividend,
    input  wire logic [mde_pkg::EXT_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [mde_pkg::DEST_W-1:0]       o_quot,
    output logic [mde_pkg::EXT_W-1:0]        o_rem
);
    import mde_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [DEST_W-1:0]   r_quot, n_quot;
    logic [EXT_W-1:0]    r_rem, n_rem;
    logic [EXT_W-1:0]    r_div, n_div;
    logic [EXT_W:0]      trial;
    logic [EXT_W:0]      diff;
    logic                ge;

    assign trial = {r_rem, r_quot[DEST_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so its top bit drops out.
            n_rem  = ge ? diff[EXT_W-1:0] : trial[EXT_W-1:0];
            n_quot = {r_quot[DEST_W-2:0], ge};
            n_cnt  = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(DEST_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: hw/rtl/mde_datapath.sv
// Datapath: code split, mixed-radix digits, target odometer and output register.
`default_nettype none

module mde_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mde_pkg::t_cfg               i_cfg,
    input  wire mde_pkg::t_cmd               i_cmd,
    output mde_pkg::t_sts                    o_sts,
    input  wire logic [mde_pkg::DEST_W-1:0]  i_dest_code,
    input  wire logic                        i_asynchronous,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [mde_pkg::NODE_W-1:0]       o_target_node,
    output logic                             o_is_broadcast,
    output logic                             o_asynchronous_out,
    output logic                             o_last_of_run
);
    import mde_pkg::*;

    logic                     div_start;
    logic [DEST_W-1:0]        div_dividend;
    logic [EXT_W-1:0]         div_divisor;
    logic                     div_done;
    logic [DEST_W-1:0]        div_quot;
    logic [EXT_W-1:0]         div_rem;

    logic                     r_async;
    logic [DEST_W-1:0]        r_mask;
    logic [EXT_W-1:0]         r_rest;
    logic [DIM_IDX_W-1:0]     r_d;
    logic [CNT_W-1:0]         r_total;
    logic [CNT_W-1:0]         r_k;
    logic [EXT_W-1:0]         r_dig [MAX_RANK];
    logic [NODE_W-1:0]        r_w   [MAX_RANK];
    logic [EXT_W-1:0]         dig_nx [MAX_RANK];
    logic [EXT_W-1:0]         ext   [MAX_RANK];

    logic                     r_out_valid;
    logic [NODE_W-1:0]        r_out_node;
    logic                     r_out_bc;
    logic                     r_out_async;
    logic                     r_out_last;

    logic [RANK_W-1:0]        rank;
    logic [EXT_W-1:0]         e_cur;
    logic [2*NODE_W-1:0]      w_prod;
    logic [2*EXT_W-1:0]       tot_prod;
    logic [CNT_W-1:0]         tot_next;
    logic [NODE_W-1:0]        node;
    logic                     is_full;
    logic                     out_free;
    logic                     emit_last;
    logic                     swept;

    assign rank  = rank_eff(i_cfg.array_rank);
    assign e_cur = ext[r_d];
    assign swept = r_mask[r_d];

    always_comb begin
        for (int i = 0; i < MAX_RANK; i++) begin
            ext[i] = extent_eff(i_cfg.dim_size[i]);
        end
    end

    // The code is divided by the node count first, then the base by each extent in turn.
    assign div_start    = i_cmd.cap_in | i_cmd.start_digit;
    assign div_dividend = i_cmd.cap_in ? i_dest_code : {{(DEST_W-EXT_W){1'b0}}, r_rest};
    assign div_divisor  = i_cmd.cap_in ? extent_eff(i_cfg.processor_count) : e_cur;

    mde_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign is_full   = (r_mask == ~({DEST_W{1'b1}} << rank));
    assign w_prod    = r_w[r_d] * e_cur[NODE_W-1:0];
    assign tot_prod  = r_total * e_cur;
    assign tot_next  = (tot_prod > (2*EXT_W)'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : tot_prod[CNT_W-1:0];
    assign emit_last = ((r_k + CNT_W'(1)) == r_total);
    assign out_free  = !r_out_valid || i_out_ready;

    // Linear node index modulo 64: only the low bits of each digit and weight matter.
    always_comb begin
        logic [2*NODE_W-1:0] prod;
        node = '0;
        for (int i = 0; i < MAX_RANK; i++) begin
            prod = r_dig[i][NODE_W-1:0] * r_w[i];
            node = node + prod[NODE_W-1:0];
        end
    end

    // Odometer over the swept dimensions; the highest swept dimension moves fastest.
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int i = MAX_RANK - 1; i >= 0; i--) begin
            dig_nx[i] = r_dig[i];
            if ((RANK_W'(i) < rank) && r_mask[i] && carry) begin
                if (r_dig[i] == ext[i] - EXT_W'(1)) begin
                    dig_nx[i] = '0;
                end else begin
                    dig_nx[i] = r_dig[i] + EXT_W'(1);
                    carry     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= CNT_W'(1);
        end else if (i_cmd.cap_code) begin
            r_total <= CNT_W'(1);
        end else if (i_cmd.cap_digit && swept) begin
            r_total <= tot_next;
        end

        if (i_cmd.cap_in) begin
            r_async <= i_asynchronous;
        end

        if (i_cmd.cap_code) begin
            r_mask <= div_quot;
            r_rest <= div_rem;
            r_d    <= '0;
            r_k    <= '0;
            for (int i = 0; i < MAX_RANK; i++) begin
                r_dig[i] <= '0;
                r_w[i]   <= (i == 0) ? NODE_W'(1) : '0;
            end
        end else if (i_cmd.cap_digit) begin
            // Swept dimensions start their sweep at coordinate zero.
            r_dig[r_d] <= swept ? '0 : div_rem;
            r_rest     <= div_quot[EXT_W-1:0];
            if (r_d != DIM_IDX_W'(MAX_RANK - 1)) begin
                r_w[r_d + DIM_IDX_W'(1)] <= w_prod[NODE_W-1:0];
            end
            r_d <= r_d + DIM_IDX_W'(1);
        end else if (i_cmd.emit_sweep) begin
            for (int i = 0; i < MAX_RANK; i++) begin
                r_dig[i] <= dig_nx[i];
            end
            r_k <= r_k + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_sweep) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end

        if (i_cmd.emit_single) begin
            r_out_node  <= is_full ? '0 : r_rest[NODE_W-1:0];
            r_out_bc    <= is_full;
            r_out_async <= r_async;
            r_out_last  <= 1'b1;
        end else if (i_cmd.emit_sweep) begin
            r_out_node  <= node;
            r_out_bc    <= 1'b0;
            r_out_async <= r_async;
            r_out_last  <= emit_last;
        end
    end

    always_comb begin
        o_sts.div_done   = div_done;
        o_sts.is_full    = is_full;
        o_sts.is_zero    = (r_mask == '0);
        o_sts.digit_last = ({1'b0, r_d} == rank - RANK_W'(1));
        o_sts.emit_last  = emit_last;
        o_sts.out_free   = out_free;
    end

    assign o_out_valid        = r_out_valid;
    assign o_target_node      = r_out_node;
    assign o_is_broadcast     = r_out_bc;
    assign o_asynchronous_out = r_out_async;
    assign o_last_of_run      = r_out_last;

`ifndef SYNTH
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_sweep |-> (r_k < r_total))
        else $error("sweep emits beyond the target count");

    a_capture_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cap_code || i_cmd.cap_digit) |-> div_done)
        else $error("divider result captured before it is done");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) && (r_total <= CNT_W'(MAX_NODES)))
        else $error("target count out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mde_ctrl.sv
// Controller state machine that sequences division, digit extraction and emission.
`default_nettype none

module mde_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mde_pkg::t_sts  i_sts,
    output mde_pkg::t_cmd       o_cmd
);
    import mde_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DIV_CODE;
                end
            end
            S_DIV_CODE: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_code = 1'b1;
                    n_state        = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                // A full or empty mask needs a single result and no digits.
                if (i_sts.is_full || i_sts.is_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_single = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_state = S_START_DIGIT;
                end
            end
            S_START_DIGIT: begin
                o_cmd.start_digit = 1'b1;
                n_state           = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_digit = 1'b1;
                    n_state         = i_sts.digit_last ? S_EMIT : S_START_DIGIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sweep = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/multicast_destination_expander.sv
// Top level: configuration registers, controller and datapath of the expander.
`default_nettype none

// Each accepted destination code is split by the node count into a replicate
// mask and a base node, using one shared divider that produces a quotient bit
// per cycle. A code whose mask is zero or full yields one result once the
// output register is free, and the next code can be taken in the cycle in
// which that result appears. Any other mask first extracts one mixed-radix
// digit per dimension through the same divider, and then delivers one target
// per cycle while the output is taken. A new code is accepted while the last
// result of the previous one still waits in the output register. Configuration
// writes are always ready and take effect at once; write them only while the
// block is idle.
module multicast_destination_expander (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mde_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [mde_pkg::DEST_W-1:0]      i_dest_code,
    input  wire logic                            i_asynchronous,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [mde_pkg::NODE_W-1:0]           o_target_node,
    output logic                                 o_is_broadcast,
    output logic                                 o_asynchronous_out,
    output logic                                 o_last_of_run
);
    import mde_pkg::*;

    t_cfg r_cfg, n_cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ARRAY_RANK: n_cfg.array_rank      = i_cfg_data[RANK_W-1:0];
                CFG_DIM_SIZE_0: n_cfg.dim_size[0]     = i_cfg_data[EXT_W-1:0];
                CFG_DIM_SIZE_1: n_cfg.dim_size[1]     = i_cfg_data[EXT_W-1:0];
                CFG_DIM_SIZE_2: n_cfg.dim_size[2]     = i_cfg_data[EXT_W-1:0];
                CFG_DIM_SIZE_3: n_cfg.dim_size[3]     = i_cfg_data[EXT_W-1:0];
                CFG_PROC_COUNT: n_cfg.processor_count = i_cfg_data[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.array_rank      <= RANK_W'(1);
            r_cfg.processor_count <= EXT_W'(1);
            for (int i = 0; i < MAX_RANK; i++) begin
                r_cfg.dim_size[i] <= EXT_W'(1);
            end
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mde_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_dest_code        (i_dest_code),
        .i_asynchronous     (i_asynchronous),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_target_node      (o_target_node),
        .o_is_broadcast     (o_is_broadcast),
        .o_asynchronous_out (o_asynchronous_out),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench of the multicast destination expander: directed and random codes.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mde_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              bcast;
        logic              async_flag;
        logic              last;
    } t_target;

    logic                  i_clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [DEST_W-1:0]     dest_code;
    logic                  async_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [NODE_W-1:0]     target_node;
    logic                  is_broadcast;
    logic                  async_out;
    logic                  last_of_run;

    multicast_destination_expander uut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_dest_code        (dest_code),
        .i_asynchronous     (async_in),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_target_node      (target_node),
        .o_is_broadcast     (is_broadcast),
        .o_asynchronous_out (async_out),
        .o_last_of_run      (last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [RANK_W-1:0] cfg_rank;
    logic [EXT_W-1:0]  cfg_dim [MAX_RANK];
    logic [EXT_W-1:0]  cfg_count;

    t_target pending_targets [$];
    t_target want;
    t_target got;

    int mismatches   = 0;
    int codes_sent   = 0;
    int targets_seen = 0;
    int reg_writes   = 0;
    int bcast_seen   = 0;

    // Sender and receiver pacing knobs, changed per phase.
    int burst_left = 0;
    int burst_max  = 1;
    int gap_max    = 0;
    int stall_pct  = 0;
    int stall_len  = 0;
    int hold_left  = 0;

    function automatic int extent(input int d);
        extent = (cfg_dim[d] == '0) ? 1 : int'(cfg_dim[d]);
    endfunction

    // Pushes every target that one destination code expands to.
    function automatic void expand_code(input logic [DEST_W-1:0] code, input logic flag);
        int count, mask, base, rank, rest, total, t, node, mult, e;
        int digit [MAX_RANK];
        int dig [MAX_RANK];
        t_target item;
        count = (cfg_count == '0) ? 1 : int'(cfg_count);
        mask  = int'(code) / count;
        base  = int'(code) % count;
        rank  = (cfg_rank == '0) ? 1
              : ((cfg_rank > RANK_W'(MAX_RANK)) ? MAX_RANK : int'(cfg_rank));
        item.async_flag = flag;
        if (mask == (1 << rank) - 1) begin
            item.node  = '0;
            item.bcast = 1'b1;
            item.last  = 1'b1;
            pending_targets.push_back(item);
        end else if (mask == 0) begin
            item.node  = NODE_W'(base);
            item.bcast = 1'b0;
            item.last  = 1'b1;
            pending_targets.push_back(item);
        end else begin
            rest  = base;
            total = 1;
            for (int d = 0; d < rank; d++) begin
                e        = extent(d);
                digit[d] = rest % e;
                rest     = rest / e;
                if ((mask >> d) & 1) begin
                    total = total * e;
                    if (total > MAX_NODES) total = MAX_NODES;
                end
            end
            // The highest swept dimension runs fastest.
            for (int k = 0; k < total; k++) begin
                t = k;
                for (int d = rank - 1; d >= 0; d--) begin
                    e = extent(d);
                    if ((mask >> d) & 1) begin
                        dig[d] = t % e;
                        t      = t / e;
                    end else begin
                        dig[d] = digit[d];
                    end
                end
                node = 0;
                mult = 1;
                for (int d = 0; d < rank; d++) begin
                    node = node + dig[d] * mult;
                    mult = mult * extent(d);
                end
                item.node  = NODE_W'(node);
                item.bcast = 1'b0;
                item.last  = (k + 1 == total);
                pending_targets.push_back(item);
            end
        end
    endfunction

    // Receiver back-pressure: ready holds each value for a random stretch.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
            hold_left <= $urandom_range(0, stall_len);
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) begin
            targets_seen++;
            got = '{target_node, is_broadcast, async_out, last_of_run};
            if (got.bcast) bcast_seen++;
            if (pending_targets.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: unexpected target node=%0d bcast=%0b async=%0b last=%0b",
                             $realtime, got.node, got.bcast, got.async_flag, got.last);
                end
            end else begin
                want = pending_targets.pop_front();
                if (got.node !== want.node || got.bcast !== want.bcast ||
                    got.async_flag !== want.async_flag || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("%0t: mismatch: expected node=%0d bcast=%0b async=%0b last=%0b",
                                 $realtime, want.node, want.bcast, want.async_flag, want.last);
                        $display("%0t:           actual   node=%0d bcast=%0b async=%0b last=%0b",
                                 $realtime, got.node, got.bcast, got.async_flag, got.last);
                    end
                end
            end
        end
    end

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_ARRAY_RANK: cfg_rank   = data[RANK_W-1:0];
            CFG_DIM_SIZE_0: cfg_dim[0] = data;
            CFG_DIM_SIZE_1: cfg_dim[1] = data;
            CFG_DIM_SIZE_2: cfg_dim[2] = data;
            CFG_DIM_SIZE_3: cfg_dim[3] = data;
            CFG_PROC_COUNT: cfg_count  = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [RANK_W-1:0] rank, input logic [EXT_W-1:0] d0,
                             input logic [EXT_W-1:0] d1, input logic [EXT_W-1:0] d2,
                             input logic [EXT_W-1:0] d3, input logic [EXT_W-1:0] count);
        write_reg(CFG_ARRAY_RANK, CFG_DATA_W'(rank));
        write_reg(CFG_DIM_SIZE_0, d0);
        write_reg(CFG_DIM_SIZE_1, d1);
        write_reg(CFG_DIM_SIZE_2, d2);
        write_reg(CFG_DIM_SIZE_3, d3);
        write_reg(CFG_PROC_COUNT, count);
        cfg_valid <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_code(input logic [DEST_W-1:0] code, input logic flag);
        if (burst_left == 0) begin
            if (gap_max != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        in_valid  <= 1'b1;
        dest_code <= code;
        async_in  <= flag;
        do @(posedge i_clk); while (!in_ready);
        expand_code(code, flag);
        codes_sent++;
        @(negedge i_clk);
    endtask

    // Waits until the block has delivered everything that is owed.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_targets.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_pace(input int gaps, input int bursts, input int stalls, input int hold);
        gap_max    = gaps;
        burst_max  = bursts;
        stall_pct  = stalls;
        stall_len  = hold;
        burst_left = 0;
    endtask

    task automatic random_pace();
        int pick;
        pick = $urandom_range(0, 3);
        set_pace($urandom_range(0, 6), $urandom_range(1, 8),
                 (pick == 0) ? 0 : ((pick == 1) ? 20 : ((pick == 2) ? 40 : 60)),
                 $urandom_range(0, 4));
    endtask

    task automatic test_reset_defaults();
        set_pace(2, 3, 30, 2);
        send_code(10'd0, 1'b0);
        send_code(10'd1, 1'b1);
        send_code(10'd2, 1'b0);
        send_code(10'd1023, 1'b1);
        settle();
    endtask

    task automatic test_mask_kinds();
        configure(3'd2, 7'd4, 7'd4, 7'd127, 7'd127, 7'd16);
        send_code(10'd5, 1'b1);
        send_code(10'(3 * 16 + 15), 1'b0);
        send_code(10'(1 * 16 + 6), 1'b1);
        send_code(10'(2 * 16 + 9), 1'b0);
        // Mask bits above the rank still take the sweep path.
        send_code(10'd1023, 1'b1);
        settle();
    endtask

    task automatic test_oversized_sweep();
        // Inconsistent extents: more than the node limit and targets wider than six bits.
        configure(3'd3, 7'd16, 7'd16, 7'd2, 7'd1, 7'd64);
        send_code(10'(3 * 64 + 17), 1'b0);
        send_code(10'(5 * 64 + 40), 1'b1);
        send_code(10'(6 * 64 + 63), 1'b0);
        send_code(10'(7 * 64), 1'b1);
        settle();
    endtask

    task automatic test_degenerate_config();
        set_pace(0, 1, 0, 0);
        configure(3'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
        send_code(10'd0, 1'b0);
        send_code(10'd1, 1'b1);
        send_code(10'd1023, 1'b0);
        settle();
        configure(3'd7, 7'd64, 7'd1, 7'd1, 7'd1, 7'd64);
        send_code(10'(15 * 64 + 3), 1'b1);
        send_code(10'(1 * 64 + 37), 1'b0);
        send_code(10'(8 * 64 + 5), 1'b1);
        settle();
        set_pace(3, 2, 50, 3);
        configure(3'd5, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
        send_code(10'(1 * 127 + 126), 1'b0);
        send_code(10'd1023, 1'b1);
        send_code(10'd0, 1'b0);
        settle();
        configure(3'd6, 7'd3, 7'd5, 7'd0, 7'd2, 7'd30);
        send_code(10'(9 * 30 + 17), 1'b1);
        settle();
    endtask

    // Consistent arrays with mostly well-formed codes and some raw noise.
    task automatic test_random_legal(input int phases, input int per_phase);
        int rank, prod, e, count, full, maxmask, mask, sel;
        logic [EXT_W-1:0] dims [MAX_RANK];
        logic [DEST_W-1:0] code;
        for (int p = 0; p < phases; p++) begin
            rank = $urandom_range(1, MAX_RANK);
            prod = 1;
            for (int d = 0; d < MAX_RANK; d++) begin
                if (d < rank) begin
                    e       = $urandom_range(1, MAX_NODES / prod);
                    dims[d] = EXT_W'(e);
                    prod    = prod * e;
                end else begin
                    dims[d] = EXT_W'($urandom_range(0, 127));
                end
            end
            configure(RANK_W'(rank), dims[0], dims[1], dims[2], dims[3], EXT_W'(prod));
            if (p == 0) set_pace(0, 1, 0, 0);
            else random_pace();
            count   = prod;
            full    = (1 << rank) - 1;
            maxmask = 1023 / count;
            for (int i = 0; i < per_phase; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    code = DEST_W'($urandom_range(0, 1023));
                end else begin
                    if (sel < 30) mask = 0;
                    else if (sel < 50) mask = full;
                    else if (sel < 90) mask = $urandom_range(1, full);
                    else if (maxmask > full) mask = $urandom_range(full + 1, maxmask);
                    else mask = full;
                    e = mask * count + $urandom_range(0, count - 1);
                    code = (e > 1023) ? DEST_W'($urandom_range(0, 1023)) : DEST_W'(e);
                end
                send_code(code, 1'($urandom_range(0, 1)));
            end
            settle();
        end
    endtask

    // Arbitrary register contents, including the unused indexes.
    task automatic test_random_raw(input int phases, input int per_phase);
        write_reg(CFG_SPARE_6, CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(CFG_SPARE_7, CFG_DATA_W'($urandom_range(0, 127)));
        cfg_valid <= 1'b0;
        for (int p = 0; p < phases; p++) begin
            configure(RANK_W'($urandom_range(0, 7)), EXT_W'($urandom_range(0, 127)),
                      EXT_W'($urandom_range(0, 127)), EXT_W'($urandom_range(0, 127)),
                      EXT_W'($urandom_range(0, 127)), EXT_W'($urandom_range(0, 127)));
            random_pace();
            for (int i = 0; i < per_phase; i++) begin
                send_code(DEST_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
            end
            settle();
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        dest_code = '0;
        async_in  = 1'b0;
        out_ready = 1'b1;
        cfg_rank  = RANK_W'(1);
        for (int d = 0; d < MAX_RANK; d++) cfg_dim[d] = EXT_W'(1);
        cfg_count = EXT_W'(1);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_mask_kinds();
        test_oversized_sweep();
        test_degenerate_config();
        test_random_legal(12, 18);
        test_random_raw(5, 16);

        settle();
        repeat (30) @(negedge i_clk);
        $display("Sent %0d destination codes over %0d register writes; %0d targets checked,",
                 codes_sent, reg_writes, targets_seen);
        $display("%0d of them broadcast markers; %0d mismatches.", bcast_seen, mismatches);
        if (mismatches == 0 && pending_targets.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d targets still owed.", pending_targets.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/mde_pkg.sv
hw/rtl/mde_div.sv
hw/rtl/mde_datapath.sv
hw/rtl/mde_ctrl.sv
hw/rtl/multicast_destination_expander.sv
tb/sv/testbench.sv
